/* hdl/ltt_pkg.sv */
// Lease token table package: field widths, codes, beat and slot structs.
// No dependencies; imported by every module of the block.
package ltt_pkg;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 31;
    localparam int EPOCH_W = 32;
    localparam int CODE_W  = 5;
    localparam int MEDIA_W = 32;
    localparam int TOK_W   = 32;
    localparam int TIME_W  = 64;
    localparam int GEN_W   = 27;
    localparam int DUR_W   = 32;
    localparam int STAT_W  = 3;

    localparam logic [GEN_W-1:0] GEN_MAX   = 27'h7FF_FFFF;
    localparam logic [GEN_W-1:0] GEN_RESET = 27'd1;
    localparam logic [DUR_W-1:0] DURATION_RESET = 32'd30000;

    // APB: byte address, one 32-bit register at word 0
    localparam int  APB_ADDR_W = 3;
    localparam int  APB_DATA_W = 32;
    localparam logic REG_LEASE_DURATION = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RENEW   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CHECK   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_BUSY    = 3'd2,
        ST_DENIED  = 3'd3,
        ST_TIMEOUT = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [ID_W-1:0]    owner_id;
        logic [EPOCH_W-1:0] owner_epoch;
        logic [CODE_W-1:0]  slot_index;
        logic [MEDIA_W-1:0] media_tag;
        logic [TOK_W-1:0]   lease_token;
        logic [TIME_W-1:0]  now_time;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic             exhausted;
        logic [TOK_W-1:0] grant_token;
        logic             lease_ok;
    } t_out_item;

    typedef struct packed {
        logic               active;
        logic [ID_W-1:0]    holder_id;
        logic [EPOCH_W-1:0] holder_epoch;
        logic [MEDIA_W-1:0] holder_media;
        logic [GEN_W-1:0]   generation;
        logic [TIME_W-1:0]  expiry;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        active: 1'b0, holder_id: '0, holder_epoch: '0, holder_media: '0,
        generation: GEN_RESET, expiry: '0
    };

    typedef struct packed {
        logic              we;
        logic [CODE_W-1:0] slot;
        t_entry            entry;
    } t_update;

endpackage

/* hdl/ltt_regs.sv */
// Lease token table configuration registers behind an APB-style port.
// Depends on ltt_pkg.
module ltt_regs
    import ltt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DUR_W-1:0]      o_duration
);

    logic [DUR_W-1:0] r_duration;
    logic             wr_hit;

    // word index is paddr[2]; byte-lane bits are ignored
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LEASE_DURATION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= DURATION_RESET;
        end else if (wr_hit) begin
            r_duration <= pwdata[DUR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LEASE_DURATION) begin
            prdata = APB_DATA_W'(r_duration);
        end
    end

    assign pready     = 1'b1;
    assign o_duration = r_duration;

endmodule

/* hdl/ltt_table.sv */
// Lease token table slot store: one flop entry per slot, async read, one write.
// Depends on ltt_pkg.
module ltt_table
    import ltt_pkg::*;
#(
    parameter int NUM_SLOTS = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CODE_W-1:0] i_rd_slot,
    output t_entry            o_rd_entry,
    input  t_update           i_upd
);

    t_entry r_entry [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!i_rst_n) begin
                r_entry[i] <= ENTRY_RESET;
            end else if (i_upd.we && i_upd.slot == CODE_W'(i)) begin
                r_entry[i] <= i_upd.entry;
            end
        end
    end

    // out-of-range slot reads as zero; the engine never uses it
    always_comb begin
        o_rd_entry = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i_rd_slot == CODE_W'(i)) begin
                o_rd_entry = r_entry[i];
            end
        end
    end

endmodule

/* hdl/ltt_engine.sv */
// Lease token table command logic: decode token, judge lease, build result/update.
// Depends on ltt_pkg; purely combinational.
module ltt_engine
    import ltt_pkg::*;
#(
    parameter int NUM_SLOTS = 31
) (
    input  logic              i_fire,
    input  t_in_item          i_item,
    input  logic [DUR_W-1:0]  i_duration,
    output logic [CODE_W-1:0] o_rd_slot,
    input  t_entry            i_entry,
    output t_out_item         o_result,
    output t_update           o_upd
);

    logic [CODE_W-1:0] code;
    logic [GEN_W-1:0]  tgen;
    logic              tok_ok;
    logic [CODE_W-1:0] tok_slot;
    logic              expired;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] deadline;
    logic              ids_zero;
    logic              owner_match;
    logic              media_match;
    logic              acq_slot_ok;
    logic [GEN_W-1:0]  gen_next;
    logic              wr;

    assign code     = i_item.lease_token[CODE_W-1:0];
    assign tgen     = i_item.lease_token[TOK_W-1:CODE_W];
    assign tok_ok   = (code != '0) && (code <= CODE_W'(NUM_SLOTS)) && (tgen != '0);
    assign tok_slot = code - CODE_W'(1);

    assign o_rd_slot = (i_item.cmd == CMD_ACQUIRE) ? i_item.slot_index : tok_slot;

    assign expired = (i_entry.expiry == '0) || (i_item.now_time >= i_entry.expiry);

    // deadline saturates at all ones on carry out
    assign sum      = {1'b0, i_item.now_time} + (TIME_W+1)'(i_duration);
    assign deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    assign ids_zero = (i_item.owner_id == '0) || (i_item.owner_epoch == '0)
                   || (i_item.media_tag == '0);
    assign owner_match = (i_entry.generation == tgen)
                      && (i_entry.holder_id == i_item.owner_id)
                      && (i_entry.holder_epoch == i_item.owner_epoch);
    assign media_match = (i_entry.holder_media == i_item.media_tag);
    assign acq_slot_ok = (i_item.slot_index < CODE_W'(NUM_SLOTS));
    assign gen_next    = i_entry.generation + GEN_W'(1);

    always_comb begin
        o_result       = '0;
        o_result.status = ST_OK;
        wr             = 1'b0;
        o_upd.slot     = o_rd_slot;
        o_upd.entry    = i_entry;

        unique case (i_item.cmd)
            CMD_ACQUIRE: begin
                if (ids_zero || !acq_slot_ok) begin
                    o_result.status = ST_INVALID;
                end else if (i_entry.active && !expired) begin
                    o_result.status = ST_BUSY;
                end else if (i_entry.generation >= GEN_MAX) begin
                    o_result.status    = ST_TIMEOUT;
                    o_result.exhausted = 1'b1;
                end else begin
                    wr = 1'b1;
                    o_upd.entry.active       = 1'b1;
                    o_upd.entry.generation   = gen_next;
                    o_upd.entry.holder_id    = i_item.owner_id;
                    o_upd.entry.holder_epoch = i_item.owner_epoch;
                    o_upd.entry.holder_media = i_item.media_tag;
                    o_upd.entry.expiry       = deadline;
                    o_result.grant_token = {gen_next, i_item.slot_index + CODE_W'(1)};
                end
            end
            CMD_RENEW: begin
                if (ids_zero || !tok_ok) begin
                    o_result.status = ST_INVALID;
                end else if (!i_entry.active || !owner_match || !media_match) begin
                    o_result.status = ST_DENIED;
                end else if (expired) begin
                    o_result.status = ST_TIMEOUT;
                end else begin
                    wr = 1'b1;
                    o_upd.entry.expiry = deadline;
                end
            end
            CMD_RELEASE: begin
                if (!tok_ok) begin
                    o_result.status = ST_INVALID;
                end else if (!i_entry.active) begin
                    o_result.status = ST_OK;
                end else if (!owner_match) begin
                    o_result.status = ST_DENIED;
                end else begin
                    // generation survives the release
                    wr = 1'b1;
                    o_upd.entry.active       = 1'b0;
                    o_upd.entry.holder_id    = '0;
                    o_upd.entry.holder_epoch = '0;
                    o_upd.entry.holder_media = '0;
                    o_upd.entry.expiry       = '0;
                end
            end
            CMD_CHECK: begin
                o_result.lease_ok = tok_ok && i_entry.active && owner_match
                                 && media_match && !expired;
            end
            default: begin
                o_result.status = ST_INVALID;
            end
        endcase

        o_upd.we = i_fire && wr;
    end

endmodule

/* hdl/lease_token_table_top.sv */
// Lease token table top level: beat registers, slot store, command logic, APB regs.
// Depends on ltt_pkg, ltt_regs, ltt_table, ltt_engine.
//
// Table of NUM_SLOTS exclusive leases, each tagged with a 27-bit generation.
// A request beat is captured in an input register; once the result register
// is free, the command logic reads the addressed slot, decides, writes the
// slot back and loads the result register, all at one clock edge. The block
// sustains one request per cycle while the result channel is not stalled:
// the read-modify-write of a single flop-based slot closes at that edge, so
// a request sees every earlier write without forwarding. A stalled result
// holds the pipe; the input register still takes a beat when empty. Slot
// state is reset directly in flops, so the block is ready right after reset
// with no clearing pass. lease_duration is written over APB at word 0 and
// must only change while no request is in flight.
module lease_token_table_top
    import ltt_pkg::*;
#(
    parameter int NUM_SLOTS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              r_in_valid;
    t_in_item          r_in_data;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              adv;       // result register free to load
    logic              fire;      // request in input register executes now
    logic [DUR_W-1:0]  duration;
    logic [CODE_W-1:0] rd_slot;
    t_entry            rd_entry;
    t_out_item         result;
    t_update           upd;

    assign adv  = !r_out_valid || !i_out_stall;
    assign fire = r_in_valid && adv;

    // input register takes a beat when empty or draining this cycle
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ltt_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_duration (duration)
    );

    ltt_engine #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_engine (
        .i_fire     (fire),
        .i_item     (r_in_data),
        .i_duration (duration),
        .o_rd_slot  (rd_slot),
        .i_entry    (rd_entry),
        .o_result   (result),
        .o_upd      (upd)
    );

    ltt_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_slot  (rd_slot),
        .o_rd_entry (rd_entry),
        .i_upd      (upd)
    );

    // ---- assertions ----

    // slot state only changes for a request that executes
    a_write_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.we |-> fire)
        else $error("slot write without executing request");

    // an executed request shows up as a result beat in the next cycle
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("executed request produced no result");

    // a token is only handed out on a successful acquire
    a_token_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.grant_token != '0) |-> (r_out_data.status == ST_OK))
        else $error("token issued with failing status");

    // exhaustion is reported as timeout status
    a_exhaust_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.exhausted) |-> (r_out_data.status == ST_TIMEOUT))
        else $error("exhausted flag without timeout status");

endmodule
